@@ hdl/nearest_sphere_hit_macros.svh @@
// Assertion macros for the nearest sphere hit block.
// Used by the top level only; needs nothing else.
`ifndef NEAREST_SPHERE_HIT_MACROS_SVH
`define NEAREST_SPHERE_HIT_MACROS_SVH
// same-cycle implication under synchronous active-low reset
`define NSH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest_sphere_hit: same-cycle check failed");
// next-cycle implication
`define NSH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest_sphere_hit: next-cycle check failed");
`endif

@@ hdl/nsh_pkg.sv @@
// Package for the nearest sphere hit block: beat types and register indexes.
// Used by the top level of the block; depends on nothing.
package nsh_pkg;
    localparam int COORD_BITS = 32;
    localparam int CFG_AW     = 3;

    localparam logic [CFG_AW-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_DIR_Z    = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_RADIUS   = 3'd6;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [COORD_BITS-1:0] center_z;
        logic                         last_vertex;
    } t_in_beat;

    typedef struct packed {
        logic                         any_hit;
        logic signed [COORD_BITS-1:0] hit_distance;
    } t_out_beat;
endpackage

@@ hdl/nsh_mul.sv @@
// Bit-serial signed multiplier: one multiplier bit per cycle, early stop.
// Standalone; used by the top level of the nearest sphere hit block.
module nsh_mul #(
    parameter int MW = 68
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [MW-1:0]   i_a,
    input  logic signed [MW-1:0]   i_b,
    output logic                   o_done,
    output logic signed [2*MW-1:0] o_prod
);
    logic            r_busy, r_done, r_neg;
    logic [2*MW-1:0] r_mc, r_acc;
    logic [MW-1:0]   r_mp;
    logic [MW-1:0]   w_abs_a, w_abs_b;

    assign w_abs_a = i_a[MW-1] ? MW'(-i_a) : MW'(i_a);
    assign w_abs_b = i_b[MW-1] ? MW'(-i_b) : MW'(i_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_mc   <= {{MW{1'b0}}, w_abs_a};
                r_mp   <= w_abs_b;
                r_acc  <= '0;
                r_neg  <= i_a[MW-1] ^ i_b[MW-1];
            end else if (r_busy) begin
                if (r_mp == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    if (r_mp[0]) r_acc <= r_acc + r_mc;
                    r_mc <= {r_mc[2*MW-2:0], 1'b0};
                    r_mp <= {1'b0, r_mp[MW-1:1]};
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_neg ? $signed(-r_acc) : $signed(r_acc);
endmodule

@@ hdl/nsh_sqrt.sv @@
// Digit-by-digit integer square root, two radicand bits per cycle.
// Standalone; used by the top level of the nearest sphere hit block.
module nsh_sqrt #(
    parameter int XW = 136
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [XW-1:0]     i_x,
    output logic              o_done,
    output logic [XW/2-1:0]   o_root
);
    localparam int HW = XW / 2;
    localparam int RW = HW + 3;
    localparam int CW = $clog2(HW + 1);

    logic          r_busy, r_done;
    logic [XW-1:0] r_x;
    logic [RW-1:0] r_rem;
    logic [HW-1:0] r_root;
    logic [CW-1:0] r_cnt;
    logic [RW-1:0] w_rem_sh, w_trial;

    assign w_rem_sh = {r_rem[RW-3:0], r_x[XW-1:XW-2]};
    assign w_trial  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_x    <= i_x;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CW'(HW);
            end else if (r_busy) begin
                r_x <= {r_x[XW-3:0], 2'b00};
                if (w_rem_sh >= w_trial) begin
                    r_rem  <= w_rem_sh - w_trial;
                    r_root <= {r_root[HW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_sh;
                    r_root <= {r_root[HW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

@@ hdl/nsh_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the top level of the nearest sphere hit block.
module nsh_div #(
    parameter int NB = 86,
    parameter int DB = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NB-1:0] i_n,
    input  logic [DB-1:0] i_d,
    output logic          o_done,
    output logic [NB-1:0] o_q,
    output logic          o_rnz
);
    localparam int CW = $clog2(NB + 1);

    logic          r_busy, r_done;
    logic [NB-1:0] r_n, r_q;
    logic [DB-1:0] r_d;
    logic [DB:0]   r_rem;
    logic [CW-1:0] r_cnt;
    logic [DB:0]   w_rs;
    logic          w_ge;

    assign w_rs = {r_rem[DB-1:0], r_n[NB-1]};
    assign w_ge = w_rs >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_n    <= i_n;
                r_d    <= i_d;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= CW'(NB);
            end else if (r_busy) begin
                r_n   <= {r_n[NB-2:0], 1'b0};
                r_rem <= w_ge ? (w_rs - {1'b0, r_d}) : w_rs;
                r_q   <= {r_q[NB-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_rnz  = |r_rem;
endmodule

@@ hdl/nearest_sphere_hit.sv @@
// Top level of the nearest sphere hit block: sequencer, accumulators, best hit.
// Depends on nsh_pkg, nsh_mul, nsh_sqrt, nsh_div and nearest_sphere_hit_macros.svh.
//
// Usage: write the ray origin, direction and sphere radius on the config port
// (index 0..6) while idle, then send sphere centres as beats on the input
// channel; the beat with last_vertex set yields one output beat carrying
// any_hit and the nearest hit_distance (0 when no hit), then the hit clears.
// Per centre: twelve bit-serial products on the shared multiplier, then
// for a candidate hit a square root of 4*COORD_BITS+8 radicand bits (two
// bits a cycle) and a division of 2*COORD_BITS+6+FRAC_BITS quotient bits
// (one a cycle). One item is in work at a time; a new centre is taken once
// the previous one is done, even while an output beat waits. A last centre
// that finds the output register still full waits until the receiver takes
// the earlier beat. Reset loads the default ray and radius and clears the
// held hit and the output valid flag.
`include "nearest_sphere_hit_macros.svh"
module nearest_sphere_hit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  nsh_pkg::t_in_beat              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output nsh_pkg::t_out_beat             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [nsh_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [nsh_pkg::COORD_BITS-1:0] i_cfg_wdata
);
    localparam int W   = nsh_pkg::COORD_BITS;
    localparam int MW  = 2 * W + 4;
    localparam int SW  = 2 * MW;
    localparam int DB  = 2 * W;
    localparam int NMW = 2 * W + 6;
    localparam int NB  = NMW + FRAC_BITS;
    localparam logic [3:0] K_LAST = 4'd11;

    typedef enum logic [2:0] {
        S_IDLE, S_MSTART, S_MWAIT, S_CHECK, S_SQRT, S_DIV, S_FIN
    } t_state;

    t_state r_state;
    logic signed [W-1:0]  r_org [3];
    logic signed [W-1:0]  r_dir [3];
    logic [W-2:0]         r_rad;
    logic signed [W:0]    r_oc [3];
    logic signed [SW-1:0] r_a, r_h, r_c, r_disc;
    logic [3:0]           r_k;
    logic                 r_last, r_hit, r_neg;
    logic                 r_best_valid;
    logic signed [W-1:0]  r_best_t;
    logic                 r_out_valid;
    nsh_pkg::t_out_beat   r_out;

    logic signed [MW-1:0] w_opa, w_opb;
    logic                 w_mul_start, w_mul_done;
    logic signed [SW-1:0] w_prod;
    logic                 w_sq_start, w_sq_done;
    logic [SW/2-1:0]      w_root;
    logic                 w_div_start, w_div_done, w_rnz;
    logic [NB-1:0]        w_q;
    logic signed [SW-1:0] w_num;
    logic [SW-1:0]        w_mag;
    logic [NB:0]          w_qa, w_lim, w_qs;
    logic signed [W-1:0]  w_t;
    logic                 w_take, w_nb_valid, w_can_emit;
    logic signed [W-1:0]  w_nb_t;

    always_comb begin
        case (r_k)
            4'd0:    begin w_opa = MW'(r_dir[0]); w_opb = MW'(r_dir[0]); end
            4'd1:    begin w_opa = MW'(r_dir[1]); w_opb = MW'(r_dir[1]); end
            4'd2:    begin w_opa = MW'(r_dir[2]); w_opb = MW'(r_dir[2]); end
            4'd3:    begin w_opa = MW'(r_dir[0]); w_opb = MW'(r_oc[0]);  end
            4'd4:    begin w_opa = MW'(r_dir[1]); w_opb = MW'(r_oc[1]);  end
            4'd5:    begin w_opa = MW'(r_dir[2]); w_opb = MW'(r_oc[2]);  end
            4'd6:    begin w_opa = MW'(r_oc[0]);  w_opb = MW'(r_oc[0]);  end
            4'd7:    begin w_opa = MW'(r_oc[1]);  w_opb = MW'(r_oc[1]);  end
            4'd8:    begin w_opa = MW'(r_oc[2]);  w_opb = MW'(r_oc[2]);  end
            4'd9:    begin
                w_opa = MW'($signed({1'b0, r_rad}));
                w_opb = MW'($signed({1'b0, r_rad}));
            end
            4'd10:   begin w_opa = r_h[MW-1:0]; w_opb = r_h[MW-1:0]; end
            default: begin w_opa = r_a[MW-1:0]; w_opb = r_c[MW-1:0]; end
        endcase
    end

    assign w_mul_start = (r_state == S_MSTART);
    assign w_sq_start  = (r_state == S_CHECK) && (r_a != '0) && !r_disc[SW-1];
    assign w_num       = -r_h - $signed(SW'(w_root));
    assign w_mag       = w_num[SW-1] ? SW'(-w_num) : SW'(w_num);
    assign w_div_start = (r_state == S_SQRT) && w_sq_done;

    nsh_mul #(.MW(MW)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mul_start),
        .i_a(w_opa), .i_b(w_opb), .o_done(w_mul_done), .o_prod(w_prod)
    );

    nsh_sqrt #(.XW(SW)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start),
        .i_x(r_disc), .o_done(w_sq_done), .o_root(w_root)
    );

    nsh_div #(.NB(NB), .DB(DB)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_n({w_mag[NMW-1:0], {FRAC_BITS{1'b0}}}), .i_d(r_a[DB-1:0]),
        .o_done(w_div_done), .o_q(w_q), .o_rnz(w_rnz)
    );

    always_comb begin
        w_qa  = {1'b0, w_q} + (NB+1)'(r_neg & w_rnz);
        w_lim = ((NB+1)'(1) << (W - 1)) - (NB+1)'(!r_neg);
        w_qs  = (w_qa > w_lim) ? w_lim : w_qa;
        w_t   = r_neg ? $signed(-w_qs[W-1:0]) : $signed(w_qs[W-1:0]);
        w_take     = r_hit && (!r_best_valid || (w_t < r_best_t));
        w_nb_valid = r_best_valid | r_hit;
        w_nb_t     = w_take ? w_t : r_best_t;
        w_can_emit = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_org[0]     <= '0;
            r_org[1]     <= '0;
            r_org[2]     <= '0;
            r_dir[0]     <= W'(1) << FRAC_BITS;
            r_dir[1]     <= '0;
            r_dir[2]     <= '0;
            r_rad        <= (W-1)'(10) << FRAC_BITS;
            r_best_valid <= 1'b0;
            r_best_t     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    nsh_pkg::CFG_ORIGIN_X: r_org[0] <= i_cfg_wdata;
                    nsh_pkg::CFG_ORIGIN_Y: r_org[1] <= i_cfg_wdata;
                    nsh_pkg::CFG_ORIGIN_Z: r_org[2] <= i_cfg_wdata;
                    nsh_pkg::CFG_DIR_X:    r_dir[0] <= i_cfg_wdata;
                    nsh_pkg::CFG_DIR_Y:    r_dir[1] <= i_cfg_wdata;
                    nsh_pkg::CFG_DIR_Z:    r_dir[2] <= i_cfg_wdata;
                    nsh_pkg::CFG_RADIUS:   r_rad    <= i_cfg_wdata[W-2:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready && !((r_state == S_FIN) && r_last)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_oc[0] <= $signed({r_org[0][W-1], r_org[0]})
                                 - $signed({i_in_data.center_x[W-1], i_in_data.center_x});
                        r_oc[1] <= $signed({r_org[1][W-1], r_org[1]})
                                 - $signed({i_in_data.center_y[W-1], i_in_data.center_y});
                        r_oc[2] <= $signed({r_org[2][W-1], r_org[2]})
                                 - $signed({i_in_data.center_z[W-1], i_in_data.center_z});
                        r_last  <= i_in_data.last_vertex;
                        r_a     <= '0;
                        r_h     <= '0;
                        r_c     <= '0;
                        r_k     <= '0;
                        r_state <= S_MSTART;
                    end
                end
                S_MSTART: r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (w_mul_done) begin
                        case (r_k)
                            4'd0, 4'd1, 4'd2: r_a    <= r_a + w_prod;
                            4'd3, 4'd4, 4'd5: r_h    <= r_h + w_prod;
                            4'd6, 4'd7, 4'd8: r_c    <= r_c + w_prod;
                            4'd9:             r_c    <= r_c - w_prod;
                            4'd10:            r_disc <= w_prod;
                            default:          r_disc <= r_disc - w_prod;
                        endcase
                        if (r_k == K_LAST) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_MSTART;
                        end
                    end
                end
                S_CHECK: begin
                    if (w_sq_start) begin
                        r_state <= S_SQRT;
                    end else begin
                        r_hit   <= 1'b0;
                        r_state <= S_FIN;
                    end
                end
                S_SQRT: begin
                    if (w_sq_done) begin
                        r_neg   <= w_num[SW-1];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_hit   <= 1'b1;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_last) begin
                        r_best_valid <= w_nb_valid;
                        r_best_t     <= w_nb_t;
                        r_state      <= S_IDLE;
                    end else if (w_can_emit) begin
                        r_out_valid        <= 1'b1;
                        r_out.any_hit      <= w_nb_valid;
                        r_out.hit_distance <= w_nb_valid ? w_nb_t : '0;
                        r_best_valid       <= 1'b0;
                        r_best_t           <= '0;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `NSH_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.any_hit, o_out_data.hit_distance == '0)
    `NSH_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `NSH_ASSERT_NOW(a_mul_done_in_wait, i_clk, i_rst_n, w_mul_done, r_state == S_MWAIT)
    `NSH_ASSERT_NOW(a_div_done_in_div, i_clk, i_rst_n, w_div_done, r_state == S_DIV)
endmodule
